// ----- design/cpa_pkg.sv -----
// Shared types and constants for the contiguous page allocator.
// No dependencies; imported by cpa_bitmap, contiguous_page_allocator, the checker and the testbench.
`default_nettype none

package cpa_pkg;

    localparam int REGIONS          = 4;
    localparam int PAGES_PER_REGION = 16384;
    localparam int PAGE_SHIFT       = 16;

    localparam int REGION_W = $clog2(REGIONS);
    localparam int PAGE_W   = $clog2(PAGES_PER_REGION);
    localparam int MAP_AW   = REGION_W + PAGE_W;
    localparam int NPG_W    = 15;   // page count fields
    localparam int FIRST_W  = 16;   // first_page field
    localparam int MARK_W   = FIRST_W + 1;
    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_RESERVE     = 2'd0;
    localparam logic [1:0] OP_FIND_REGION = 2'd1;
    localparam logic [1:0] OP_FIND_ANY    = 2'd2;

    // register index map: bases first, then page counts
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_FIRST = 3'd4;

    localparam logic [ADDR_W-1:0] BASE_RESET [REGIONS] = '{
        32'h4000_0000, 32'h4030_0000, 32'h8000_0000, 32'h8100_0000
    };
    localparam logic [NPG_W-1:0] PAGES_RESET [REGIONS] = '{
        15'd2, 15'd16335, 15'd255, 15'd16127
    };

    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         region;
        logic [FIRST_W-1:0] first_page;
        logic [NPG_W-1:0]   page_count;
        logic               align;
        logic               reserve;
    } cpa_req_t;

    typedef struct packed {
        logic               found;
        logic [ADDR_W-1:0]  address;
        logic [1:0]         found_region;
        logic [COUNT_W-1:0] allocated_count;
    } cpa_rsp_t;

    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        logic              wdata;
        logic [MAP_AW-1:0] raddr;
    } cpa_mem_req_t;

endpackage

`default_nettype wire

// ----- design/cpa_bitmap.sv -----
// Reserved-page bitmap: one bit per page of every region, one write and
// one registered read per cycle. Depends on cpa_pkg.
`default_nettype none

module cpa_bitmap (
    input  wire logic                  clk,
    input  wire cpa_pkg::cpa_mem_req_t mem_req,
    output logic                       rd_bit
);
    import cpa_pkg::*;

    logic map_mem [0:(1 << MAP_AW)-1];

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            map_mem[mem_req.waddr] <= mem_req.wdata;
        end
        rd_bit <= map_mem[mem_req.raddr];
    end

endmodule

`default_nettype wire

// ----- design/contiguous_page_allocator.sv -----
// Top level of the contiguous page allocator: sequencer, registers, counts.
// Depends on cpa_pkg and cpa_bitmap.
`default_nettype none

// First-fit page allocator over four regions. After reset the block clears
// the page bitmap (req_stall high; config writes are taken). One transaction
// is worked at a time; req_stall stays high until the result is loaded into
// the output register. The bitmap RAM is touched one page per clock, and a
// full output register under rsp_stall holds the result back. A reserve marks
// its pages and then loads the result; a zero-length find or an unused code
// goes straight to the result; a find scans page by page, moving on to the
// next region when a find-any exhausts one, then forms the address, marks
// the run when reserving it, and loads the result.
module contiguous_page_allocator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [cpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cpa_pkg::ADDR_W-1:0]    cfg_data,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire cpa_pkg::cpa_req_t            req,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output cpa_pkg::cpa_rsp_t                 rsp
);
    import cpa_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_ADDR  = 6'b001000,
        ST_MARK  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  base_reg  [REGIONS];
    logic [NPG_W-1:0]   pages_reg [REGIONS];
    logic [COUNT_W-1:0] count_reg [REGIONS];

    logic [MAP_AW-1:0]   clr_reg, clr_next;
    logic [REGION_W-1:0] region_reg, region_next;
    logic                any_reg, any_next;
    logic                align_reg, align_next;
    logic                resv_reg, resv_next;
    logic                zero_reg, zero_next;
    logic                found_reg, found_next;
    logic [NPG_W-1:0]    n_reg, n_next;
    logic [NPG_W-1:0]    issue_reg, issue_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [PAGE_W-1:0]   ev_page_reg, ev_page_next;
    logic [NPG_W-1:0]    run_reg, run_next;
    logic [NPG_W-1:0]    mod_reg, mod_next;
    logic [PAGE_W-1:0]   start_reg, start_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [MARK_W-1:0]   pg_reg, pg_next;
    logic [NPG_W-1:0]    rem_reg, rem_next;
    logic                rsp_valid_reg, rsp_valid_next;
    cpa_rsp_t            rsp_reg, rsp_next;

    logic         count_inc;
    cpa_mem_req_t mem_req;
    logic         rd_bit;
    logic [NPG_W-1:0] lim;
    logic             page_ok;

    cpa_bitmap u_bitmap (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_bit  (rd_bit)
    );

    // usable pages of the current region, clamped to the region size
    always_comb
    begin
        if (pages_reg[region_reg] > NPG_W'(PAGES_PER_REGION))
        begin
            lim = NPG_W'(PAGES_PER_REGION);
        end
        else
        begin
            lim = pages_reg[region_reg];
        end
    end

    assign page_ok = !rd_bit && (!align_reg || (run_reg != '0) || (mod_reg == '0));

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        region_next    = region_reg;
        any_next       = any_reg;
        align_next     = align_reg;
        resv_next      = resv_reg;
        zero_next      = zero_reg;
        found_next     = found_reg;
        n_next         = n_reg;
        issue_next     = issue_reg;
        ev_valid_next  = 1'b0;
        ev_page_next   = ev_page_reg;
        run_next       = run_reg;
        mod_next       = mod_reg;
        start_next     = start_reg;
        addr_next      = addr_reg;
        pg_next        = pg_reg;
        rem_next       = rem_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        count_inc      = 1'b0;
        mem_req.we     = 1'b0;
        mem_req.waddr  = {region_reg, pg_reg[PAGE_W-1:0]};
        mem_req.wdata  = 1'b1;
        mem_req.raddr  = {region_reg, issue_reg[PAGE_W-1:0]};

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                mem_req.wdata = 1'b0;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    any_next    = (req.operation == OP_FIND_ANY);
                    region_next = (req.operation == OP_FIND_ANY) ? '0 : req.region;
                    align_next  = req.align;
                    resv_next   = req.reserve;
                    n_next      = req.page_count;
                    found_next  = 1'b0;
                    zero_next   = (req.operation != OP_RESERVE) &&
                                  (req.operation != OP_FIND_REGION);
                    issue_next  = '0;
                    run_next    = '0;
                    mod_next    = '0;
                    pg_next     = MARK_W'(req.first_page);
                    rem_next    = req.page_count;
                    if (req.operation == OP_RESERVE)
                    begin
                        state_next = ST_MARK;
                    end
                    else if ((req.operation == OP_FIND_REGION ||
                              req.operation == OP_FIND_ANY) && req.page_count != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle, evaluate the previous page's bit
                if (issue_reg < lim)
                begin
                    ev_valid_next = 1'b1;
                    ev_page_next  = issue_reg[PAGE_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                end
                if (ev_valid_reg)
                begin
                    mod_next = (mod_reg == n_reg - 1'b1) ? '0 : mod_reg + 1'b1;
                    if (page_ok)
                    begin
                        run_next = run_reg + 1'b1;
                        if (run_reg + 1'b1 == n_reg)
                        begin
                            start_next = ev_page_reg - PAGE_W'(n_reg - 1'b1);
                            state_next = ST_ADDR;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else if (issue_reg >= lim)
                begin
                    // region exhausted
                    issue_next = '0;
                    run_next   = '0;
                    mod_next   = '0;
                    if (any_reg && region_reg != REGION_W'(REGIONS - 1))
                    begin
                        region_next = region_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_ADDR:
            begin
                addr_next  = base_reg[region_reg] + (ADDR_W'(start_reg) << PAGE_SHIFT);
                found_next = 1'b1;
                zero_next  = 1'b0;
                pg_next    = MARK_W'(start_reg);
                rem_next   = n_reg;
                state_next = resv_reg ? ST_MARK : ST_DONE;
            end

            ST_MARK:
            begin
                if (rem_reg == '0 || pg_reg >= MARK_W'(lim))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_req.we = 1'b1;
                    count_inc  = 1'b1;
                    pg_next    = pg_reg + 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.found           = found_reg;
                    rsp_next.address         = found_reg ? addr_reg : '0;
                    rsp_next.found_region    = zero_reg ? '0 : region_reg;
                    rsp_next.allocated_count = zero_reg ? '0 : count_reg[region_reg];
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            ev_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ev_valid_reg  <= ev_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        region_reg  <= region_next;
        any_reg     <= any_next;
        align_reg   <= align_next;
        resv_reg    <= resv_next;
        zero_reg    <= zero_next;
        found_reg   <= found_next;
        n_reg       <= n_next;
        issue_reg   <= issue_next;
        ev_page_reg <= ev_page_next;
        run_reg     <= run_next;
        mod_reg     <= mod_next;
        start_reg   <= start_next;
        addr_reg    <= addr_next;
        pg_reg      <= pg_next;
        rem_reg     <= rem_next;
        rsp_reg     <= rsp_next;
    end

    // configuration registers and per-region counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < REGIONS; r++)
            begin
                base_reg[r]  <= BASE_RESET[r];
                pages_reg[r] <= PAGES_RESET[r];
                count_reg[r] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index < CFG_PAGES_FIRST)
                begin
                    base_reg[cfg_index[REGION_W-1:0]] <= cfg_data;
                end
                else
                begin
                    pages_reg[cfg_index[REGION_W-1:0]] <= cfg_data[NPG_W-1:0];
                end
            end
            if (count_inc && count_reg[region_reg] != '1)
            begin
                count_reg[region_reg] <= count_reg[region_reg] + 1'b1;
            end
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- dv/cpa_alloc_checker.sv -----
// Checker for the contiguous page allocator: mirrors the page bitmaps, region
// registers and allocation counts, predicts each result and compares it.
// Depends on cpa_pkg.
`timescale 1ns / 1ps

module cpa_alloc_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [cpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpa_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                     req_valid,
    input  logic                     req_stall,
    input  cpa_pkg::cpa_req_t        req,
    input  logic                     rsp_valid,
    input  logic                     rsp_stall,
    input  cpa_pkg::cpa_rsp_t        rsp,
    output int                       mismatches,
    output int                       outstanding
);
    import cpa_pkg::*;

    logic [ADDR_W-1:0]  base_cfg  [REGIONS];
    logic [NPG_W-1:0]   pages_cfg [REGIONS];
    logic [COUNT_W-1:0] alloc_cnt [REGIONS];
    bit                 page_taken [REGIONS][PAGES_PER_REGION];
    cpa_rsp_t           pending_results [$];

    function automatic int unsigned usable_pages(int unsigned r);
        return (pages_cfg[r] > PAGES_PER_REGION) ? PAGES_PER_REGION : pages_cfg[r];
    endfunction

    // every marked page bumps the count, already-reserved pages included
    function automatic void mark_pages(int unsigned r, int unsigned first, int unsigned n);
        int unsigned lim;
        int unsigned k;
        lim = usable_pages(r);
        for (k = 0; k < n; k++)
        begin
            if (first + k >= lim)
                break;
            page_taken[r][first + k] = 1'b1;
            if (alloc_cnt[r] != {COUNT_W{1'b1}})
                alloc_cnt[r] = alloc_cnt[r] + 1'b1;
        end
    endfunction

    // first fit; with align set a run may only open at a multiple of n
    function automatic bit first_run(int unsigned r, int unsigned n, bit aligned,
                                     output int unsigned start);
        int unsigned lim;
        int unsigned run;
        int unsigned pg;
        lim = usable_pages(r);
        run = 0;
        start = 0;
        if (n == 0)
            return 1'b0;
        for (pg = 0; pg < lim; pg++)
        begin
            if (!page_taken[r][pg] && (!aligned || run > 0 || (pg % n) == 0))
            begin
                run++;
                if (run == n)
                begin
                    start = pg + 1 - n;
                    return 1'b1;
                end
            end
            else
                run = 0;
        end
        return 1'b0;
    endfunction

    function automatic cpa_rsp_t predict_alloc(cpa_req_t q);
        cpa_rsp_t    o;
        int unsigned start;
        int unsigned r;
        bit          hit;
        o = '0;
        hit = 1'b0;
        case (q.operation)
            OP_RESERVE:
            begin
                mark_pages(q.region, q.first_page, q.page_count);
                o.found_region    = q.region;
                o.allocated_count = alloc_cnt[q.region];
            end
            OP_FIND_REGION:
            begin
                o.found_region = q.region;
                if (first_run(q.region, q.page_count, q.align, start))
                begin
                    o.found   = 1'b1;
                    o.address = base_cfg[q.region] + (ADDR_W'(start) << PAGE_SHIFT);
                    if (q.reserve)
                        mark_pages(q.region, start, q.page_count);
                end
                o.allocated_count = alloc_cnt[q.region];
            end
            OP_FIND_ANY:
            begin
                for (r = 0; r < REGIONS && !hit; r++)
                begin
                    if (first_run(r, q.page_count, q.align, start))
                    begin
                        hit = 1'b1;
                        o.found   = 1'b1;
                        o.address = base_cfg[r] + (ADDR_W'(start) << PAGE_SHIFT);
                        if (q.reserve)
                            mark_pages(r, start, q.page_count);
                        o.found_region    = 2'(r);
                        o.allocated_count = alloc_cnt[r];
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic check_field(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cpa_rsp_t want;
        int       r;
        int       pg;
        if (!rst_n)
        begin
            for (r = 0; r < REGIONS; r++)
            begin
                base_cfg[r]  = BASE_RESET[r];
                pages_cfg[r] = PAGES_RESET[r];
                alloc_cnt[r] = '0;
                for (pg = 0; pg < PAGES_PER_REGION; pg++)
                    page_taken[r][pg] = 1'b0;
            end
            pending_results.delete();
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index < CFG_PAGES_FIRST)
                    base_cfg[cfg_index[1:0]] = cfg_data;
                else
                    pages_cfg[cfg_index[1:0]] = cfg_data[NPG_W-1:0];
            end
            if (req_valid && !req_stall)
                pending_results.push_back(predict_alloc(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result expected none actual %p", $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("found", ADDR_W'(want.found), ADDR_W'(rsp.found));
                    check_field("address", want.address, rsp.address);
                    check_field("found_region", ADDR_W'(want.found_region),
                                ADDR_W'(rsp.found_region));
                    check_field("allocated_count", ADDR_W'(want.allocated_count),
                                ADDR_W'(rsp.allocated_count));
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Top of the contiguous page allocator testbench: clock, reset, register
// writes, directed and random transactions, random stalls and the verdict.
// Depends on cpa_pkg, contiguous_page_allocator and cpa_alloc_checker.
`timescale 1ns / 1ps

module testbench;
    import cpa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FIRST = 3'd0;
    localparam logic [1:0]           OP_UNUSED      = 2'd3;
    localparam int                   CYCLE_LIMIT    = 5_000_000;
    localparam int                   PHASES         = 5;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 req_valid;
    logic                 req_stall;
    cpa_req_t             req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    cpa_rsp_t             rsp;
    int                   mismatches;
    int                   outstanding;
    int                   cycle_count;
    bit                   calm;

    logic [ADDR_W-1:0] region_base  [REGIONS];
    logic [NPG_W-1:0]  region_pages [REGIONS];

    contiguous_page_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    cpa_alloc_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("contiguous_page_allocator: mismatch");
            $finish;
        end
    end

    // result-side backpressure in random bursts, none once calm is set
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    function automatic cpa_req_t alloc_req(logic [1:0] op, logic [1:0] rg, int unsigned first,
                                           int unsigned n, bit al, bit rs);
        cpa_req_t q;
        q.operation  = op;
        q.region     = rg;
        q.first_page = FIRST_W'(first);
        q.page_count = NPG_W'(n);
        q.align      = al;
        q.reserve    = rs;
        return q;
    endfunction

    function automatic cpa_req_t random_alloc(int unsigned span, bit short_runs);
        cpa_req_t    q;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        q.operation = (pick < 35) ? OP_RESERVE :
                      (pick < 70) ? OP_FIND_REGION :
                      (pick < 97) ? OP_FIND_ANY : OP_UNUSED;
        q.region = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0)
            q.first_page = FIRST_W'($urandom());
        else
            q.first_page = FIRST_W'($urandom_range(0, span));
        pick = $urandom_range(0, 9);
        if (short_runs)
            q.page_count = NPG_W'($urandom_range(1, 4));
        else if (pick < 6)
            q.page_count = NPG_W'($urandom_range(0, 6));
        else if (pick < 9)
            q.page_count = NPG_W'($urandom_range(0, 64));
        else
            q.page_count = NPG_W'($urandom_range(0, PAGES_PER_REGION));
        q.align   = 1'($urandom());
        q.reserve = 1'($urandom());
        return q;
    endfunction

    // payload holds until the transaction is taken; valid stays up between items unless a random gap is drawn
    task automatic send_alloc(cpa_req_t item);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_region_regs();
        int k;
        for (k = 0; k < REGIONS; k++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(CFG_BASE_FIRST + k);
            cfg_data  <= region_base[k];
            @(negedge clk);
            cfg_index <= CFG_IDX_W'(CFG_PAGES_FIRST + k);
            cfg_data  <= ADDR_W'(region_pages[k]);
            @(negedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int ph;
        int k;
        int items;
        bit wide;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        req_valid   = 1'b0;
        req         = '0;
        calm        = 1'b0;
        cycle_count = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // registers at their reset values: region 0 holds only two pages
        send_alloc(alloc_req(OP_FIND_REGION, 2'd0, 0, 1, 1'b0, 1'b0));
        send_alloc(alloc_req(OP_FIND_REGION, 2'd0, 0, 0, 1'b0, 1'b1));   // zero run length
        send_alloc(alloc_req(OP_FIND_REGION, 2'd0, 0, 2, 1'b0, 1'b1));
        send_alloc(alloc_req(OP_FIND_REGION, 2'd0, 0, 1, 1'b0, 1'b0));   // region full
        send_alloc(alloc_req(OP_FIND_ANY, 2'd0, 0, 1, 1'b0, 1'b1));
        send_alloc(alloc_req(OP_RESERVE, 2'd1, 1, 3, 1'b0, 1'b0));
        send_alloc(alloc_req(OP_FIND_REGION, 2'd1, 0, 4, 1'b1, 1'b0));
        send_alloc(alloc_req(OP_RESERVE, 2'd2, 16'hFFFF, PAGES_PER_REGION, 1'b0, 1'b0));
        send_alloc(alloc_req(OP_UNUSED, 2'd3, 16'hFFFF, PAGES_PER_REGION, 1'b1, 1'b1));
        send_alloc(alloc_req(OP_FIND_ANY, 2'd3, 0, PAGES_PER_REGION - 1, 1'b0, 1'b1));
        send_alloc(alloc_req(OP_FIND_ANY, 2'd0, 0, 3, 1'b1, 1'b1));
        settle();

        // extreme bases and page counts; region 2 wraps to address zero
        region_base[0]  = 32'h0000_0000;
        region_base[1]  = 32'hFFFF_FFFF;
        region_base[2]  = 32'hFFFF_0000;
        region_base[3]  = 32'h8000_0000;
        region_pages[0] = NPG_W'(PAGES_PER_REGION);
        region_pages[1] = '0;
        region_pages[2] = NPG_W'(3);
        region_pages[3] = NPG_W'(PAGES_PER_REGION);
        write_region_regs();
        send_alloc(alloc_req(OP_FIND_REGION, 2'd0, 0, 1, 1'b0, 1'b0));
        send_alloc(alloc_req(OP_RESERVE, 2'd2, 0, 1, 1'b0, 1'b0));
        send_alloc(alloc_req(OP_FIND_REGION, 2'd2, 0, 2, 1'b0, 1'b1));
        send_alloc(alloc_req(OP_FIND_REGION, 2'd1, 0, 1, 1'b0, 1'b1));
        send_alloc(alloc_req(OP_FIND_ANY, 2'd0, 0, 1, 1'b1, 1'b0));
        // upper half of region 3 marked eight times drives its count to saturation
        for (k = 0; k < 8; k++)
            send_alloc(alloc_req(OP_RESERVE, 2'd3, PAGES_PER_REGION / 2,
                                 PAGES_PER_REGION, 1'b0, 1'b0));
        send_alloc(alloc_req(OP_FIND_REGION, 2'd3, 0, PAGES_PER_REGION / 2, 1'b1, 1'b0));
        send_alloc(alloc_req(OP_FIND_REGION, 2'd3, 0, PAGES_PER_REGION / 2 + 1, 1'b0, 1'b1));

        // random phases: small regions keep scans short, one phase uses large ones
        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            wide  = (ph == 3);
            calm  = (ph == PHASES - 1);
            items = wide ? 10 : (calm ? 24 : 22);
            for (k = 0; k < REGIONS; k++)
            begin
                region_base[k] = $urandom();
                if (wide)
                    region_pages[k] = NPG_W'($urandom_range(0, PAGES_PER_REGION));
                else
                    region_pages[k] = NPG_W'($urandom_range(0, 160));
            end
            write_region_regs();
            for (k = 0; k < items; k++)
                send_alloc(random_alloc(wide ? PAGES_PER_REGION + 16 : 176, wide));
        end

        settle();
        repeat (16) @(negedge clk);
        if (mismatches == 0)
            $display("contiguous_page_allocator: match");
        else
            $display("contiguous_page_allocator: mismatch");
        $finish;
    end

endmodule
